// ===== src/stroke_length_and_bounds_defines.svh =====
// assertion macros for the stroke length and bounds block
`ifndef STROKE_LENGTH_AND_BOUNDS_DEFINES_SVH
`define STROKE_LENGTH_AND_BOUNDS_DEFINES_SVH

`ifndef SYNTHESIS

// condition checked at every edge out of reset
`define SLA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// trigger implies a result in the following cycle
`define SLA_ASSERT_NEXT(lbl, trig, res, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (res)) else $error(msg);

`else

`define SLA_ASSERT(lbl, cond, msg)
`define SLA_ASSERT_NEXT(lbl, trig, res, msg)

`endif

`endif

// ===== src/sla_pkg.sv =====
// shared constants and types for the stroke length and bounds block
package sla_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int OUT_W          = 16;
  localparam int LEN_W          = 32;
  localparam int CNT_W          = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULX,
    ST_MULY,
    ST_ADD,
    ST_ROOT,
    ST_ACC,
    ST_FIN
  } state_t;

endpackage

// ===== src/sla_if.sv =====
// point and result channel interfaces
interface sla_in_if #(
  parameter int COORD_BITS = sla_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;
  logic                         end_of_stroke;

  modport source (output valid, px, py, end_of_stroke, input ready);
  modport sink   (input valid, px, py, end_of_stroke, output ready);
endinterface

interface sla_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [sla_pkg::OUT_W-1:0]  box_left;
  logic signed [sla_pkg::OUT_W-1:0]  box_top;
  logic        [sla_pkg::OUT_W-1:0]  box_width;
  logic        [sla_pkg::OUT_W-1:0]  box_height;
  logic        [sla_pkg::LEN_W-1:0]  path_length;
  logic        [sla_pkg::CNT_W-1:0]  point_count;

  modport source (output valid, box_left, box_top, box_width, box_height, path_length,
                  point_count, input ready);
  modport sink   (input valid, box_left, box_top, box_width, box_height, path_length,
                  point_count, output ready);
endinterface

// ===== src/stroke_length_and_bounds.sv =====
// Stroke length and bounding box accumulator.
// in_ch carries the points of a touch stroke (px, py signed Q12.4, end_of_stroke
// marks the last one); a beat is taken when valid and ready are both high.
// out_ch gives one beat per stroke: box left/top, width/height, path length
// (Q28.4, saturating) and point count (saturating), taken on valid and ready.
// Sequence: the first point of a stroke is taken with no length step. Every
// later point is taken and forms |dx|, |dy|, then goes through the one shared
// multiplier for dx^2 and dy^2, one add, the square root (one root bit per cycle
// from a single compare and subtract), and an add into the length. The point
// flagged last then goes through a final step that loads the output register.
// in_ch.ready is high only while the sequencer is idle.
// The output register lets the next stroke start while a result waits; if the
// receiver stalls, the block holds at the end of the following stroke until
// the pending result is taken.
// Reset (rst_n low, synchronous) closes any open stroke and drops a pending result.
`include "stroke_length_and_bounds_defines.svh"

module stroke_length_and_bounds #(
  parameter int COORD_BITS = sla_pkg::COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sla_in_if.sink    in_ch,
  sla_out_if.source out_ch
);

  localparam int CW    = COORD_BITS;
  localparam int NPAIR = CW + 1;
  localparam int RADW  = 2 * NPAIR;
  localparam int RTW   = CW + 1;
  localparam int REMW  = CW + 2;
  localparam int ITW   = $clog2(NPAIR + 1);
  localparam int SUMW  = ((RTW > sla_pkg::LEN_W) ? RTW : sla_pkg::LEN_W) + 1;
  localparam int OW    = sla_pkg::OUT_W;
  localparam int LW    = sla_pkg::LEN_W;
  localparam int NW    = sla_pkg::CNT_W;

  sla_pkg::state_t state_r, state_nxt;

  logic                 in_stroke_r;
  logic                 last_r;
  logic signed [CW-1:0] prev_x_r, prev_y_r;
  logic signed [CW-1:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic        [LW-1:0] length_r;
  logic        [NW-1:0] count_r;
  logic        [CW-1:0] ax_r, ay_r;
  logic      [2*CW-1:0] prod_r;
  logic      [RADW-1:0] rad_r;
  logic      [REMW-1:0] rem_r;
  logic       [RTW-1:0] root_r;
  logic       [ITW-1:0] iter_r;

  logic                 out_valid_r;
  logic signed [OW-1:0] out_left_r, out_top_r;
  logic        [OW-1:0] out_width_r, out_height_r;
  logic        [LW-1:0] out_length_r;
  logic        [NW-1:0] out_count_r;

  // control decoded from the state
  logic in_ready;
  logic mul_sel_y;
  logic fin_go;
  logic take;

  assign take = in_ch.valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sla_pkg::ST_IDLE: begin
        if (take) begin
          if (in_stroke_r) state_nxt = sla_pkg::ST_MULX;
          else if (in_ch.end_of_stroke) state_nxt = sla_pkg::ST_FIN;
        end
      end
      sla_pkg::ST_MULX: state_nxt = sla_pkg::ST_MULY;
      sla_pkg::ST_MULY: state_nxt = sla_pkg::ST_ADD;
      sla_pkg::ST_ADD:  state_nxt = sla_pkg::ST_ROOT;
      sla_pkg::ST_ROOT: begin
        if (iter_r == ITW'(NPAIR - 1)) state_nxt = sla_pkg::ST_ACC;
      end
      sla_pkg::ST_ACC:  state_nxt = last_r ? sla_pkg::ST_FIN : sla_pkg::ST_IDLE;
      sla_pkg::ST_FIN: begin
        if (!out_valid_r || out_ch.ready) state_nxt = sla_pkg::ST_IDLE;
      end
      default: state_nxt = sla_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    mul_sel_y = 1'b0;
    fin_go    = 1'b0;
    unique case (state_r)
      sla_pkg::ST_IDLE: in_ready  = 1'b1;
      sla_pkg::ST_MULY: mul_sel_y = 1'b1;
      sla_pkg::ST_FIN:  fin_go    = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  // point differences against the previous point
  logic signed [CW:0] dx, dy, ndx, ndy;
  assign dx  = {in_ch.px[CW-1], in_ch.px} - {prev_x_r[CW-1], prev_x_r};
  assign dy  = {in_ch.py[CW-1], in_ch.py} - {prev_y_r[CW-1], prev_y_r};
  assign ndx = -dx;
  assign ndy = -dy;

  // shared multiplier
  logic   [CW-1:0] mul_in;
  logic [2*CW-1:0] mul_out;
  assign mul_in  = mul_sel_y ? ay_r : ax_r;
  assign mul_out = mul_in * mul_in;

  // one root digit per cycle
  logic        [1:0] pair;
  logic [REMW+1:0] rem_t, trial, rem_d;
  logic              ge;
  assign pair  = rad_r[RADW-1 -: 2];
  assign rem_t = {rem_r, pair};
  assign trial = {1'b0, root_r, 2'b01};
  assign ge    = rem_t >= trial;
  assign rem_d = rem_t - trial;

  // saturating length add
  logic [SUMW-1:0] len_sum;
  logic            len_sat;
  assign len_sum = SUMW'(length_r) + SUMW'(root_r);
  assign len_sat = (len_sum[SUMW-1:LW] != '0) || (&len_sum[LW-1:0]);

  // box extents cut or extended to the output width
  logic signed [CW:0] wd, ht;
  logic      [OW-1:0] left_o, top_o, width_o, height_o;
  assign wd = {max_x_r[CW-1], max_x_r} - {min_x_r[CW-1], min_x_r};
  assign ht = {max_y_r[CW-1], max_y_r} - {min_y_r[CW-1], min_y_r};

  generate
    if (CW >= OW) begin : g_pos_cut
      assign left_o = min_x_r[OW-1:0];
      assign top_o  = min_y_r[OW-1:0];
    end else begin : g_pos_ext
      assign left_o = {{(OW-CW){min_x_r[CW-1]}}, min_x_r};
      assign top_o  = {{(OW-CW){min_y_r[CW-1]}}, min_y_r};
    end
    if (CW + 1 >= OW) begin : g_ext_cut
      assign width_o  = wd[OW-1:0];
      assign height_o = ht[OW-1:0];
    end else begin : g_ext_pad
      assign width_o  = {{(OW-CW-1){1'b0}}, wd};
      assign height_o = {{(OW-CW-1){1'b0}}, ht};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sla_pkg::ST_IDLE;
      in_stroke_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // a new result wins over the beat leaving in the same cycle
      if (fin_go) begin
        out_valid_r <= 1'b1;
        in_stroke_r <= 1'b0;
      end else begin
        if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
        if (take) in_stroke_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r <= '0;
      prev_y_r <= '0;
      min_x_r  <= '0;
      max_x_r  <= '0;
      min_y_r  <= '0;
      max_y_r  <= '0;
      length_r <= '0;
      count_r  <= '0;
    end else begin
      if (take) begin
        prev_x_r <= in_ch.px;
        prev_y_r <= in_ch.py;
        last_r   <= in_ch.end_of_stroke;
        ax_r     <= dx[CW] ? ndx[CW-1:0] : dx[CW-1:0];
        ay_r     <= dy[CW] ? ndy[CW-1:0] : dy[CW-1:0];
        if (!in_stroke_r) begin
          min_x_r  <= in_ch.px;
          max_x_r  <= in_ch.px;
          min_y_r  <= in_ch.py;
          max_y_r  <= in_ch.py;
          length_r <= '0;
          count_r  <= NW'(1);
        end else begin
          if (in_ch.px < min_x_r) min_x_r <= in_ch.px;
          if (in_ch.px > max_x_r) max_x_r <= in_ch.px;
          if (in_ch.py < min_y_r) min_y_r <= in_ch.py;
          if (in_ch.py > max_y_r) max_y_r <= in_ch.py;
          if (count_r != '1) count_r <= count_r + NW'(1);
        end
      end
      unique case (state_r)
        sla_pkg::ST_MULX: prod_r <= mul_out;
        sla_pkg::ST_MULY: begin
          prod_r <= mul_out;
          rad_r  <= {2'b00, prod_r};
        end
        sla_pkg::ST_ADD: begin
          rad_r  <= rad_r + {2'b00, prod_r};
          rem_r  <= '0;
          root_r <= '0;
          iter_r <= '0;
        end
        sla_pkg::ST_ROOT: begin
          rad_r  <= {rad_r[RADW-3:0], 2'b00};
          rem_r  <= ge ? rem_d[REMW-1:0] : rem_t[REMW-1:0];
          root_r <= {root_r[RTW-2:0], ge};
          iter_r <= iter_r + ITW'(1);
        end
        sla_pkg::ST_ACC:  length_r <= len_sat ? '1 : len_sum[LW-1:0];
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_left_r   <= left_o;
      out_top_r    <= top_o;
      out_width_r  <= width_o;
      out_height_r <= height_o;
      out_length_r <= length_r;
      out_count_r  <= count_r;
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.box_left    = out_left_r;
  assign out_ch.box_top     = out_top_r;
  assign out_ch.box_width   = out_width_r;
  assign out_ch.box_height  = out_height_r;
  assign out_ch.path_length = out_length_r;
  assign out_ch.point_count = out_count_r;

  `SLA_ASSERT(a_root_iter_bound, (state_r != sla_pkg::ST_ROOT) || (iter_r < ITW'(NPAIR)), "root iteration past last digit")
  `SLA_ASSERT(a_count_nonzero, !in_stroke_r || (count_r != '0), "open stroke with zero point count")
  `SLA_ASSERT(a_box_order, !in_stroke_r || ((min_x_r <= max_x_r) && (min_y_r <= max_y_r)), "box minimum above maximum")
  `SLA_ASSERT_NEXT(a_len_monotone, (state_r == sla_pkg::ST_ACC), (length_r >= $past(length_r)), "path length decreased")
  `SLA_ASSERT(a_out_from_fin, !(out_valid_r && !$past(out_valid_r)) || ($past(state_r) == sla_pkg::ST_FIN), "result loaded outside final step")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// testbench top for stroke_length_and_bounds: directed and random strokes checked on the fly
module tb_top;

  localparam logic signed [15:0] COORD_MIN = 16'sh8000;
  localparam logic signed [15:0] COORD_MAX = 16'sh7FFF;
  localparam int RANDOM_POINTS = 1850;
  // max-size diagonal segments for a large running length
  localparam int LONG_POINTS = 60;

  typedef struct packed {
    logic [sla_pkg::OUT_W-1:0] box_left;
    logic [sla_pkg::OUT_W-1:0] box_top;
    logic [sla_pkg::OUT_W-1:0] box_width;
    logic [sla_pkg::OUT_W-1:0] box_height;
    logic [sla_pkg::LEN_W-1:0] path_length;
    logic [sla_pkg::CNT_W-1:0] point_count;
  } stroke_summary_t;

  logic clk;
  logic rst_n;

  sla_in_if  in_ch ();
  sla_out_if out_ch ();

  stroke_length_and_bounds i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // local stroke tracker
  logic                      stroke_open = 1'b0;
  logic signed [15:0]        pen_x = '0;
  logic signed [15:0]        pen_y = '0;
  logic signed [15:0]        left_x = '0;
  logic signed [15:0]        right_x = '0;
  logic signed [15:0]        top_y = '0;
  logic signed [15:0]        bottom_y = '0;
  logic [sla_pkg::LEN_W-1:0] length_acc = '0;
  logic [sla_pkg::CNT_W-1:0] point_acc = '0;
  stroke_summary_t           expected_summaries[$];

  int failures = 0;
  int points_sent = 0;
  int strokes_done = 0;
  int summaries_checked = 0;

  // sender and receiver idling
  int          gap_max = 0;
  int          burst_left = 0;
  logic [15:0] stall_pattern = '1;
  int          stall_phase = 0;
  int          hold_request = 0;
  int          hold_left = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #8_000_000;
    $display("tb_top failed");
    $finish;
  end

  task automatic track_point(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic last);
    longint          dx;
    longint          dy;
    longint unsigned sq;
    longint unsigned root;
    longint unsigned trial;
    longint unsigned total;
    stroke_summary_t s;
    if (!stroke_open) begin
      left_x     = x;
      right_x    = x;
      top_y      = y;
      bottom_y   = y;
      length_acc = '0;
      point_acc  = {{(sla_pkg::CNT_W-1){1'b0}}, 1'b1};
      stroke_open = 1'b1;
    end else begin
      dx = x - pen_x;
      dy = y - pen_y;
      sq = dx * dx + dy * dy;
      // floor square root, one result bit at a time from the top
      root = 0;
      for (int b = 17; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= sq) root = trial;
      end
      total = length_acc + root;
      if (total > 64'hFFFF_FFFF) length_acc = '1;
      else length_acc = total[31:0];
      if (x < left_x) left_x = x;
      if (x > right_x) right_x = x;
      if (y < top_y) top_y = y;
      if (y > bottom_y) bottom_y = y;
      if (point_acc != '1) point_acc++;
    end
    pen_x = x;
    pen_y = y;
    if (last) begin
      s.box_left    = left_x;
      s.box_top     = top_y;
      s.box_width   = right_x - left_x;
      s.box_height  = bottom_y - top_y;
      s.path_length = length_acc;
      s.point_count = point_acc;
      expected_summaries = {expected_summaries, s};
      stroke_open = 1'b0;
      strokes_done++;
    end
  endtask

  // called at a rising edge; returns at the edge where the beat was taken
  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic last);
    if (gap_max > 0 && burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    if (burst_left > 0) burst_left--;
    in_ch.valid         <= 1'b1;
    in_ch.px            <= x;
    in_ch.py            <= y;
    in_ch.end_of_stroke <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    track_point(x, y, last);
    points_sent++;
  endtask

  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_summaries.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(input int gap, input bit stall);
    logic [31:0] r;
    gap_max    = gap;
    burst_left = 0;
    if (stall) begin
      r = $urandom;
      stall_pattern = r[15:0] | 16'h0001;
    end else begin
      stall_pattern = '1;
    end
  endtask

  function automatic logic signed [15:0] next_coord(input logic signed [15:0] near);
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0, 1: return r[15:0];
      2: begin
        case (r[1:0])
          2'd0: return COORD_MIN;
          2'd1: return COORD_MAX;
          2'd2: return '0;
          default: return '1;
        endcase
      end
      // mostly nearby points, as a real pen moves
      default: return near + $signed({1'b0, r[6:0]}) - 16'sd64;
    endcase
  endfunction

  task automatic test_directed();
    set_idling(0, 0);
    // single-point strokes at the origin and two corners
    send_point(0, 0, 1);
    send_point(COORD_MIN, COORD_MAX, 1);
    send_point(COORD_MAX, COORD_MIN, 1);
    // full-range diagonal, widest box
    send_point(COORD_MIN, COORD_MIN, 0);
    send_point(COORD_MAX, COORD_MAX, 1);
    send_point(COORD_MAX, COORD_MIN, 0);
    send_point(COORD_MIN, COORD_MAX, 0);
    send_point(0, 0, 1);
    // repeated point, zero-length segments
    send_point(5, 5, 0);
    send_point(5, 5, 0);
    send_point(5, 5, 1);
    // two axis-aligned segments from the origin, then a diagonal to (-1, -1)
    send_point(0, 0, 0);
    send_point(100, 0, 0);
    send_point(100, -100, 0);
    send_point(-1, -1, 1);
    // exact 3-4-5 and a floored diagonal
    send_point(0, 0, 0);
    send_point(48, 64, 1);
    send_point(-1, 1, 0);
    send_point(0, 0, 1);
    pause_until_drained();
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    hold_request = 400;
    // sender keeps offering while results back up
    for (int s = 0; s < 6; s++) begin
      send_point(16'(s * 16), 16'(-s * 16), 0);
      send_point(16'(s * 16 + 300), 200, 0);
      send_point(16'(-s), 16'(s), 1);
    end
    pause_until_drained();
  endtask

  task automatic test_long_stroke();
    logic signed [15:0] c;
    set_idling(0, 0);
    for (int i = 0; i < LONG_POINTS; i++) begin
      c = (i % 2 == 0) ? COORD_MIN : COORD_MAX;
      send_point(c, c, 0);
    end
    // short finish inside the full-range box
    send_point(100, -100, 0);
    send_point(0, 0, 1);
    pause_until_drained();
  endtask

  task automatic test_random();
    int n;
    int k;
    int len;
    logic signed [15:0] x;
    logic signed [15:0] y;
    n = 0;
    k = 0;
    x = '0;
    y = '0;
    while (n < RANDOM_POINTS) begin
      if (k % 30 == 0) begin
        case ($urandom_range(0, 3))
          0: set_idling(0, 0);
          1: set_idling(4, 0);
          2: set_idling(0, 1);
          default: set_idling(12, 1);
        endcase
      end
      case ($urandom_range(0, 9))
        0, 1: len = 1;
        8: len = $urandom_range(7, 20);
        9: len = $urandom_range(21, 60);
        default: len = $urandom_range(2, 6);
      endcase
      for (int i = 0; i < len; i++) begin
        x = next_coord(x);
        y = next_coord(y);
        send_point(x, y, i == len - 1);
        n++;
      end
      k++;
    end
    pause_until_drained();
  endtask

  initial begin : result_receiver
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= stall_pattern[stall_phase];
        stall_phase = (stall_phase + 1) % 16;
      end
    end
  end

  always @(posedge clk) begin : check_results
    stroke_summary_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_summaries.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected stroke summary beat at %0t", $time);
      end else begin
        want = expected_summaries.pop_front();
        summaries_checked++;
        if (out_ch.box_left !== want.box_left || out_ch.box_top !== want.box_top ||
            out_ch.box_width !== want.box_width || out_ch.box_height !== want.box_height ||
            out_ch.path_length !== want.path_length ||
            out_ch.point_count !== want.point_count) begin
          failures++;
          if (failures <= 10) begin
            $display("summary mismatch at %0t: exp left %0d top %0d w %0d h %0d len %0d cnt %0d",
                     $time, $signed(want.box_left), $signed(want.box_top), want.box_width,
                     want.box_height, want.path_length, want.point_count);
            $display("  got left %0d top %0d w %0d h %0d len %0d cnt %0d",
                     $signed(out_ch.box_left), $signed(out_ch.box_top), out_ch.box_width,
                     out_ch.box_height, out_ch.path_length, out_ch.point_count);
          end
        end
      end
    end
  end

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.px            = '0;
    in_ch.py            = '0;
    in_ch.end_of_stroke = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    test_long_stroke();
    pause_until_drained();
    repeat (40) @(posedge clk);
    failures += expected_summaries.size();
    $display("ran %0d points in %0d strokes: corner boxes, zero and diagonal segments,",
             points_sent, strokes_done);
    $display("a stalled result path and a long full-range stroke; %0d summaries compared",
             summaries_checked);
    if (failures == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
